@@ hw/rtl/pal_pkg.sv @@
// Package for the positional array list: sizes, widths and the cell command type.
package pal_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = 7;
    localparam int DATA_W    = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } pal_action_t;

    // Broadcast to every cell in the row.
    typedef struct packed
    {
        logic                     ins_en;
        logic                     rem_en;
        logic [CNT_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } pal_cmd_t;

endpackage

@@ hw/rtl/pal_if.sv @@
// Channel interfaces for the positional array list: request, result and configuration.
interface pal_req_if
    import pal_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface pal_rsp_if
    import pal_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [CNT_W-1:0] entry_total;
    logic             is_empty;
    logic             is_full;
    logic [CNT_W-1:0] odd_total;

    modport source (output valid, output accepted, output entry_total, output is_empty,
                    output is_full, output odd_total, input ready);
    modport sink   (input valid, input accepted, input entry_total, input is_empty,
                    input is_full, input odd_total, output ready);
endinterface

interface pal_cfg_if
    import pal_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

@@ hw/rtl/pal_cell.sv @@
// One list slot: holds an entry and shifts it to or from its neighbours.
module pal_cell
    import pal_pkg::*;
(
    input  logic                     clk,
    input  pal_cmd_t                 cmd,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     hit_odd
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CNT_W-1:0]         idx_ext;

    assign idx_ext = CNT_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins_en)
        begin
            if (idx_ext > cmd.pos)
            begin
                data_next = left_data;
            end
            else if (idx_ext == cmd.pos)
            begin
                data_next = cmd.value;
            end
        end
        else if (cmd.rem_en)
        begin
            if (idx_ext >= cmd.pos)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign hit_odd = cmd.rem_en && (idx_ext == cmd.pos) && data_reg[0];

endmodule

@@ hw/rtl/positional_array_list.sv @@
// Top level of the positional array list: row of cells, counters and result register.
// Ordered list of up to MAX_DEPTH signed 32-bit entries held in a row of cells. Each
// request inserts at or removes from a 0-based position; all later cells shift together in
// the same clock, and a new request is taken every cycle while the result register is
// empty or being drained. The result is registered and appears in the cycle after the
// request is taken. Capacity is written through the configuration channel, which is
// always ready; no reset sweep is needed, slots beyond the count are never read.
module positional_array_list
    import pal_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pal_req_if.sink    req,
    pal_rsp_if.source  rsp,
    pal_cfg_if.sink    cfg
);

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] odd_reg;
    logic [CNT_W-1:0] odd_next;
    logic [CNT_W-1:0] cap_eff;

    logic             rsp_valid_reg;
    logic             accepted_reg;
    logic             full_reg;

    logic             fire;
    logic             ins_ok;
    logic             rem_ok;
    pal_cmd_t         cmd;

    logic signed [DATA_W-1:0] cell_data [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]     cell_hit;

    assign cap_eff = (cap_reg > CNT_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : cap_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign ins_ok = fire && (pal_action_t'(req.action) == ACT_INSERT)
                    && (count_reg < cap_eff) && (count_reg < CNT_W'(MAX_DEPTH));
    assign rem_ok = fire && (pal_action_t'(req.action) == ACT_REMOVE)
                    && (req.position < count_reg) && (req.position < CNT_W'(MAX_DEPTH));

    always_comb
    begin
        cmd.ins_en = ins_ok;
        cmd.rem_en = rem_ok;
        cmd.value  = req.value;
        // insert past the end appends
        cmd.pos    = (ins_ok && (req.position > count_reg)) ? count_reg : req.position;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = req.value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == MAX_DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            pal_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .idx        (IDX_W'(gi)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .hit_odd    (cell_hit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        odd_next   = odd_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
            if (req.value[0])
            begin
                odd_next = odd_reg + CNT_W'(1);
            end
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CNT_W'(1);
            if (|cell_hit)
            begin
                odd_next = odd_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            odd_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.capacity_in_use;
            end
            count_reg <= count_next;
            odd_reg   <= odd_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            accepted_reg <= ins_ok || rem_ok;
            full_reg     <= (count_next >= cap_eff);
        end
    end

    // count and odd total are live state; they only move on a taken request
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.accepted    = accepted_reg;
    assign rsp.entry_total = count_reg;
    assign rsp.is_empty    = (count_reg == '0);
    assign rsp.is_full     = full_reg;
    assign rsp.odd_total   = odd_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DEPTH))
        else $error("entry count beyond store depth");

    a_odd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        odd_reg <= count_reg)
        else $error("odd total exceeds entry count");

    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        rem_ok |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not decrement count");

    a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !fire)
        else $error("request taken while result stalled");

endmodule
